/* rtl/core/rfb_pkg.sv */
// Shared constants and types for the rectangle fill and bitmap blit engine.
package rfb_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_W  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_H  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_W   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_H   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FILL     = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OP_MODE  = 4'd7;

	typedef enum logic {
		MODE_BLIT = 1'b0,
		MODE_FILL = 1'b1
	} op_mode_t;

	// Field widths
	localparam int FIELD_W   = 13;  // raw width of a dimension or origin write
	localparam int ORG_W     = 12;  // clamped origin, never negative
	localparam int COLOUR_W  = 24;
	localparam int BYTE_W    = 8;
	localparam int WORD_W    = 32;
	localparam int ADDR_W    = 26;
	localparam int WADDR_W   = ADDR_W - 2;  // address in pixels, modulo the byte range

	localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [BYTE_W-1:0] ALPHA_CLEAR  = 8'h00;

	// Queue depths
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

endpackage

/* rtl/core/rfb_fifo.sv */
// Small register queue used between the front, the back and the result port.
module rfb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == NW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(DEPTH))
		else $error("queue fill count beyond depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + NW'(1)))
		else $error("queue fill count did not grow on push");

endmodule

/* rtl/core/rfb_front.sv */
// Front part: configuration registers, raster walk, clipping and pixel word formation.
module rfb_front #(
	parameter int MAX_DIM = 4096,
	localparam int DW = $clog2(MAX_DIM + 1),
	localparam int CW = $clog2(MAX_DIM)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [rfb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rfb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           push,
	input  logic [rfb_pkg::BYTE_W-1:0]     src_byte0,
	input  logic [rfb_pkg::BYTE_W-1:0]     src_byte1,
	input  logic [rfb_pkg::BYTE_W-1:0]     src_byte2,
	input  logic                           mid_full,
	output logic                           mid_push,
	output logic [CW-1:0]                  mid_px,
	output logic [CW-1:0]                  mid_py,
	output logic [rfb_pkg::WORD_W-1:0]     mid_word,
	output logic [DW-1:0]                  frame_w
);
	localparam int SW     = ((CW > rfb_pkg::ORG_W) ? CW : rfb_pkg::ORG_W) + 1;
	localparam int RST_FW = (640 > MAX_DIM) ? MAX_DIM : 640;
	localparam int RST_FH = (480 > MAX_DIM) ? MAX_DIM : 480;

	logic [DW-1:0]                fw_q;
	logic [DW-1:0]                fh_q;
	logic [DW-1:0]                rw_q;
	logic [DW-1:0]                rh_q;
	logic [rfb_pkg::ORG_W-1:0]    ox_q;
	logic [rfb_pkg::ORG_W-1:0]    oy_q;
	logic [rfb_pkg::COLOUR_W-1:0] fill_q;
	rfb_pkg::op_mode_t            mode_q;
	logic [CW-1:0]                col_q;
	logic [CW-1:0]                row_q;

	logic [rfb_pkg::FIELD_W-1:0]  raw13;
	logic [DW-1:0]                dim_sat;
	logic [rfb_pkg::ORG_W-1:0]    org_clamp;
	logic                         accept;
	logic                         active;
	logic [SW-1:0]                px_w;
	logic [SW-1:0]                py_w;
	logic                         in_frame;
	logic [DW-1:0]                col_inc;
	logic [DW-1:0]                row_inc;

	assign raw13     = cfg_data[rfb_pkg::FIELD_W-1:0];
	assign dim_sat   = (32'(raw13) > MAX_DIM) ? DW'(MAX_DIM) : DW'(raw13);
	assign org_clamp = raw13[rfb_pkg::FIELD_W-1] ? '0 : raw13[rfb_pkg::ORG_W-1:0];

	assign accept   = push && !mid_full;
	assign active   = (rw_q != '0) && (rh_q != '0);
	assign px_w     = SW'(ox_q) + SW'(col_q);
	assign py_w     = SW'(oy_q) + SW'(row_q);
	assign in_frame = (32'(px_w) < 32'(fw_q)) && (32'(py_w) < 32'(fh_q));
	assign col_inc  = DW'(col_q) + DW'(1);
	assign row_inc  = DW'(row_q) + DW'(1);

	assign mid_push = accept && active && in_frame;
	assign mid_px   = px_w[CW-1:0];
	assign mid_py   = py_w[CW-1:0];
	assign mid_word = (mode_q == rfb_pkg::MODE_FILL) ?
		{rfb_pkg::ALPHA_CLEAR, fill_q} :
		{rfb_pkg::ALPHA_OPAQUE, src_byte2, src_byte1, src_byte0};
	assign frame_w  = fw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q   <= DW'(RST_FW);
			fh_q   <= DW'(RST_FH);
			rw_q   <= '0;
			rh_q   <= '0;
			ox_q   <= '0;
			oy_q   <= '0;
			fill_q <= '0;
			mode_q <= rfb_pkg::MODE_BLIT;
			col_q  <= '0;
			row_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				rfb_pkg::REG_FRAME_W:  fw_q   <= dim_sat;
				rfb_pkg::REG_FRAME_H:  fh_q   <= dim_sat;
				rfb_pkg::REG_ORIGIN_X: ox_q   <= org_clamp;
				rfb_pkg::REG_ORIGIN_Y: oy_q   <= org_clamp;
				rfb_pkg::REG_RECT_W:   rw_q   <= dim_sat;
				rfb_pkg::REG_RECT_H:   rh_q   <= dim_sat;
				rfb_pkg::REG_FILL:     fill_q <= cfg_data[rfb_pkg::COLOUR_W-1:0];
				rfb_pkg::REG_OP_MODE:  mode_q <= rfb_pkg::op_mode_t'(cfg_data[0]);
				default: ;
			endcase
			// restart the walk on any known register
			if (cfg_index <= rfb_pkg::REG_OP_MODE) begin
				col_q <= '0;
				row_q <= '0;
			end
		end else if (accept && active) begin
			if (col_inc >= rw_q) begin
				col_q <= '0;
				row_q <= (row_inc >= rh_q) ? '0 : row_inc[CW-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index <= rfb_pkg::REG_OP_MODE) |=> (col_q == '0 && row_q == '0))
		else $error("walk not restarted after register write");

	a_col_in_rect: assert property (@(posedge clk) disable iff (!arst_n)
		(rw_q != '0) |-> (DW'(col_q) < rw_q))
		else $error("column beyond rectangle width");

endmodule

/* rtl/core/rfb_back.sv */
// Back part: row times pitch multiply, then byte address and word into the result queue.
module rfb_back #(
	parameter int MAX_DIM = 4096,
	localparam int DW = $clog2(MAX_DIM + 1),
	localparam int CW = $clog2(MAX_DIM)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         mid_empty,
	input  logic [CW-1:0]                mid_px,
	input  logic [CW-1:0]                mid_py,
	input  logic [rfb_pkg::WORD_W-1:0]   mid_word,
	input  logic [DW-1:0]                frame_w,
	output logic                         mid_pop,
	input  logic                         out_full,
	output logic                         out_push,
	output logic [rfb_pkg::ADDR_W-1:0]   out_addr,
	output logic [rfb_pkg::WORD_W-1:0]   out_word
);
	logic                          valid_s1;
	logic [rfb_pkg::WADDR_W-1:0]   prod_s1;
	logic [CW-1:0]                 px_s1;
	logic [rfb_pkg::WORD_W-1:0]    word_s1;
	logic [CW+DW-1:0]              prod_w;
	logic [rfb_pkg::WADDR_W-1:0]   pix_addr;
	logic                          load;

	assign prod_w   = mid_py * frame_w;
	assign out_push = valid_s1 && !out_full;
	assign load     = !mid_empty && (!valid_s1 || out_push);
	assign mid_pop  = load;
	assign pix_addr = prod_s1 + rfb_pkg::WADDR_W'(px_s1);
	assign out_addr = {pix_addr, 2'b00};
	assign out_word = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (out_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= rfb_pkg::WADDR_W'(prod_w);
			px_s1   <= mid_px;
			word_s1 <= mid_word;
		end
	end

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_full) |=> (valid_s1 && $stable(prod_s1) && $stable(word_s1)))
		else $error("stalled pixel lost in back stage");

endmodule

/* rtl/core/rect_fill_and_bitmap_blit.sv */
// Top level of the rectangle fill and bitmap blit engine.
//
// Channel   Direction  Handshake               Payload
// input     in         push / full             src_byte0, src_byte1, src_byte2
// result    out        empty / pop             byte_address, pixel_word
// config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item a cycle sustained while full is low; a walked and clipped pixel inside the frame goes
// through the middle queue and the back stage register (row times pitch multiply) to the result queue.
// Reset restores the default registers and the walk at column 0, row 0.
// A stalled result side fills the result queue, then the middle queue, then raises full.
// Configuration writes are always taken (cfg_ready is tied high).
module rect_fill_and_bitmap_blit #(
	parameter int MAX_DIM = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [rfb_pkg::BYTE_W-1:0]     src_byte0,
	input  logic [rfb_pkg::BYTE_W-1:0]     src_byte1,
	input  logic [rfb_pkg::BYTE_W-1:0]     src_byte2,
	output logic                           empty,
	input  logic                           pop,
	output logic [rfb_pkg::ADDR_W-1:0]     byte_address,
	output logic [rfb_pkg::WORD_W-1:0]     pixel_word,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rfb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rfb_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int CW    = $clog2(MAX_DIM);
	localparam int MID_W = 2 * CW + rfb_pkg::WORD_W;
	localparam int OUT_W = rfb_pkg::ADDR_W + rfb_pkg::WORD_W;

	logic                         mid_push;
	logic                         mid_full;
	logic                         mid_pop;
	logic                         mid_empty;
	logic [CW-1:0]                f_px;
	logic [CW-1:0]                f_py;
	logic [rfb_pkg::WORD_W-1:0]   f_word;
	logic [CW-1:0]                b_px;
	logic [CW-1:0]                b_py;
	logic [rfb_pkg::WORD_W-1:0]   b_word;
	logic [DW-1:0]                frame_w;
	logic                         out_push;
	logic                         out_full;
	logic [rfb_pkg::ADDR_W-1:0]   out_addr;
	logic [rfb_pkg::WORD_W-1:0]   out_word;

	assign cfg_ready = 1'b1;
	assign full      = mid_full;

	rfb_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.src_byte0 (src_byte0),
		.src_byte1 (src_byte1),
		.src_byte2 (src_byte2),
		.mid_full  (mid_full),
		.mid_push  (mid_push),
		.mid_px    (f_px),
		.mid_py    (f_py),
		.mid_word  (f_word),
		.frame_w   (frame_w)
	);

	rfb_fifo #(.WIDTH(MID_W), .DEPTH(rfb_pkg::MID_DEPTH)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  ({f_px, f_py, f_word}),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  ({b_px, b_py, b_word}),
		.empty  (mid_empty)
	);

	rfb_back #(.MAX_DIM(MAX_DIM)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_px    (b_px),
		.mid_py    (b_py),
		.mid_word  (b_word),
		.frame_w   (frame_w),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_addr  (out_addr),
		.out_word  (out_word)
	);

	rfb_fifo #(.WIDTH(OUT_W), .DEPTH(rfb_pkg::OUT_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  ({out_addr, out_word}),
		.full   (out_full),
		.pop    (pop),
		.rdata  ({byte_address, pixel_word}),
		.empty  (empty)
	);

endmodule
